@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rycc_pkg.sv @@
// Types, coefficients and constants shared by the colour converter pipeline.
package rycc_pkg;

    localparam int NUM_LANES   = 3;
    localparam int NUM_TERMS   = 3;
    localparam int OP_W        = 9;
    localparam int COEF_W      = 19;
    localparam int PROD_W      = OP_W + COEF_W;
    localparam int MAG_W       = 25;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 32;
    localparam int QUO_W       = 9;
    localparam int DIV_W       = 17;
    localparam int SCALED_W    = QUO_W + DIV_W;
    localparam int REM_W       = 18;
    localparam int VAL_W       = 11;

    // All coefficients share a factor of eight with the scale of one million,
    // so the scale drops to 125000 and the rounding half to 62500.
    localparam logic [DIV_W-1:0]   DIVISOR = 17'd125000;
    localparam logic [MAG_W-1:0]   HALF    = 25'd62500;
    // floor(2^32 / 125000); the quotient estimate is then low by at most one.
    localparam logic [RECIP_W-1:0] RECIP   = 16'd34359;

    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Rows are output lanes, columns the weights of comp_a, comp_b, comp_c.
    localparam coef_t COEF_FWD [NUM_LANES][NUM_TERMS] = '{
        '{ 19'sd37375,   19'sd73375,   19'sd14250},
        '{-19'sd21092,  -19'sd41408,   19'sd62500},
        '{ 19'sd62500,  -19'sd52336,  -19'sd10164}
    };

    localparam coef_t COEF_INV [NUM_LANES][NUM_TERMS] = '{
        '{ 19'sd0,       19'sd0,       19'sd175250},
        '{ 19'sd0,      -19'sd43017,  -19'sd89267},
        '{ 19'sd0,       19'sd221500,  19'sd0}
    };

    typedef struct packed {
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p0;
        logic [7:0]               base;
    } prod_lane_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [7:0]       base;
    } mag_lane_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [QUO_W-1:0] qest;
        logic [7:0]       base;
    } quo_lane_t;

endpackage

@@ rtl/rycc_mul_stage.sv @@
// First pipeline stage: operand selection and the nine weighted products.
module rycc_mul_stage (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  logic                                          direction,
    input  logic [7:0]                                    comp_a,
    input  logic [7:0]                                    comp_b,
    input  logic [7:0]                                    comp_c,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output rycc_pkg::prod_lane_t [rycc_pkg::NUM_LANES-1:0] lanes
);
    import rycc_pkg::*;

    logic                              valid_reg;
    logic                              valid_next;
    logic                              take;
    logic                              load;
    logic signed [OP_W-1:0]            op [NUM_TERMS];
    logic signed [PROD_W-1:0]          prod [NUM_LANES][NUM_TERMS];
    logic [7:0]                        base [NUM_LANES];
    prod_lane_t [NUM_LANES-1:0]        lanes_reg;
    prod_lane_t [NUM_LANES-1:0]        lanes_next;

    // In the inverse direction the chroma inputs are centered on zero.
    always_comb
    begin
        op[0] = $signed({1'b0, comp_a});
        if (direction == DIR_INV)
        begin
            op[1] = $signed({1'b0, comp_b}) - $signed({1'b0, CHROMA_OFFSET});
            op[2] = $signed({1'b0, comp_c}) - $signed({1'b0, CHROMA_OFFSET});
        end
        else
        begin
            op[1] = $signed({1'b0, comp_b});
            op[2] = $signed({1'b0, comp_c});
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        for (genvar t = 0; t < NUM_TERMS; t++)
        begin : g_term
            assign prod[l][t] = op[t] * ((direction == DIR_INV) ? COEF_INV[l][t]
                                                                : COEF_FWD[l][t]);
        end
        assign base[l] = (direction == DIR_INV) ? comp_a
                       : ((l == 0) ? 8'd0 : CHROMA_OFFSET);
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lanes_next[l].p0   = prod[l][0];
            lanes_next[l].p1   = prod[l][1];
            lanes_next[l].p2   = prod[l][2];
            lanes_next[l].base = base[l];
        end
    end

    assign take       = !valid_reg || dn_ready;
    assign load       = take && up_valid;
    assign valid_next = take ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign lanes    = lanes_reg;

endmodule

@@ rtl/rycc_sum_stage.sv @@
// Second pipeline stage: sum of products, sign split and rounding offset.
module rycc_sum_stage (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  rycc_pkg::prod_lane_t [rycc_pkg::NUM_LANES-1:0] up_lanes,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output rycc_pkg::mag_lane_t [rycc_pkg::NUM_LANES-1:0]  lanes
);
    import rycc_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic                      take;
    logic                      load;
    logic signed [PROD_W-1:0]  sum [NUM_LANES];
    logic [PROD_W-1:0]         absval [NUM_LANES];
    mag_lane_t [NUM_LANES-1:0] lanes_reg;
    mag_lane_t [NUM_LANES-1:0] lanes_next;

    // Rounding half away from zero works on the magnitude, so the sign is kept aside.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            sum[l]             = up_lanes[l].p0 + up_lanes[l].p1 + up_lanes[l].p2;
            absval[l]          = sum[l][PROD_W-1] ? PROD_W'(-sum[l]) : PROD_W'(sum[l]);
            lanes_next[l].neg  = sum[l][PROD_W-1];
            lanes_next[l].mag  = absval[l][MAG_W-1:0] + HALF;
            lanes_next[l].base = up_lanes[l].base;
        end
    end

    assign take       = !valid_reg || dn_ready;
    assign load       = take && up_valid;
    assign valid_next = take ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign lanes    = lanes_reg;

endmodule

@@ rtl/rycc_recip_stage.sv @@
// Third pipeline stage: quotient estimate by multiplication with a reciprocal.
module rycc_recip_stage (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  rycc_pkg::mag_lane_t [rycc_pkg::NUM_LANES-1:0]  up_lanes,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output rycc_pkg::quo_lane_t [rycc_pkg::NUM_LANES-1:0]  lanes
);
    import rycc_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic                         take;
    logic                         load;
    logic [MAG_W+RECIP_W-1:0]     scaled [NUM_LANES];
    quo_lane_t [NUM_LANES-1:0]    lanes_reg;
    quo_lane_t [NUM_LANES-1:0]    lanes_next;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            scaled[l]          = (MAG_W+RECIP_W)'(up_lanes[l].mag) * (MAG_W+RECIP_W)'(RECIP);
            lanes_next[l].neg  = up_lanes[l].neg;
            lanes_next[l].mag  = up_lanes[l].mag;
            lanes_next[l].qest = scaled[l][RECIP_SHIFT +: QUO_W];
            lanes_next[l].base = up_lanes[l].base;
        end
    end

    assign take       = !valid_reg || dn_ready;
    assign load       = take && up_valid;
    assign valid_next = take ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign lanes    = lanes_reg;

endmodule

@@ rtl/rycc_out_stage.sv @@
// Fourth pipeline stage: quotient correction, offset, clamp and output register.
module rycc_out_stage (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  rycc_pkg::quo_lane_t [rycc_pkg::NUM_LANES-1:0]  up_lanes,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output logic [rycc_pkg::NUM_LANES-1:0][7:0]           pix
);
    import rycc_pkg::*;

    logic                              valid_reg;
    logic                              valid_next;
    logic                              take;
    logic                              load;
    logic [SCALED_W-1:0]               back [NUM_LANES];
    logic [SCALED_W-1:0]               diff [NUM_LANES];
    logic [REM_W-1:0]                  rem [NUM_LANES];
    logic [QUO_W-1:0]                  quo [NUM_LANES];
    logic signed [VAL_W-1:0]           val [NUM_LANES];
    logic [NUM_LANES-1:0][7:0]         pix_reg;
    logic [NUM_LANES-1:0][7:0]         pix_next;

    // The estimate is low by at most one, so a single compare fixes it.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            back[l] = SCALED_W'(up_lanes[l].qest) * SCALED_W'(DIVISOR);
            diff[l] = SCALED_W'(up_lanes[l].mag) - back[l];
            rem[l]  = diff[l][REM_W-1:0];
            quo[l]  = up_lanes[l].qest + QUO_W'(rem[l] >= REM_W'(DIVISOR));
            if (up_lanes[l].neg)
            begin
                val[l] = $signed({3'b000, up_lanes[l].base}) - $signed({2'b00, quo[l]});
            end
            else
            begin
                val[l] = $signed({3'b000, up_lanes[l].base}) + $signed({2'b00, quo[l]});
            end
            priority if (val[l][VAL_W-1] || (val[l] == '0))
            begin
                pix_next[l] = 8'd0;
            end
            else if (val[l][VAL_W-1:8] != '0)
            begin
                pix_next[l] = 8'd255;
            end
            else
            begin
                pix_next[l] = val[l][7:0];
            end
        end
    end

    assign take       = !valid_reg || dn_ready;
    assign load       = take && up_valid;
    assign valid_next = take ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign pix      = pix_reg;

endmodule

@@ rtl/rgb_ycbcr_colour_converter.sv @@
// Top level of the full-range RGB / YCbCr colour converter pipeline.
//
//   Channel   Signals                                   Direction
//   input     in_valid, in_stall, comp_a/b/c            pixel transaction in
//   output    out_valid, out_stall, out_a/b/c           pixel transaction out
//   config    cfg_wr_en, cfg_wr_data                    direction register write
//
// Throughput is one pixel transaction per clock while out_stall is low; the pipeline
// stages are multiply, sum, reciprocal multiply, and correct and clamp.
// The widest path is the 25 by 16 bit reciprocal multiplier in the third stage.
// rst_n clears all valid bits and sets the direction to RGB to YCbCr.
// Each stage holds its transaction while the next one is full and stalled, so a
// stall on the output only reaches in_stall once every stage is occupied.
`include "assert_macros.svh"

module rgb_ycbcr_colour_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] comp_a,
    input  logic [7:0] comp_b,
    input  logic [7:0] comp_c,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_a,
    output logic [7:0] out_b,
    output logic [7:0] out_c
);
    import rycc_pkg::*;

    // Direction register: 0 converts RGB to YCbCr, 1 converts YCbCr to RGB.
    // The user must write it only while the pipeline is empty, so the first stage
    // can sample it directly; the block itself does not enforce this.
    logic direction_reg;
    logic direction_next;

    logic s1_ready;
    logic s1_valid;
    logic s2_ready;
    logic s2_valid;
    logic s3_ready;
    logic s3_valid;
    logic s4_ready;

    prod_lane_t [NUM_LANES-1:0] s1_lanes;
    mag_lane_t  [NUM_LANES-1:0] s2_lanes;
    quo_lane_t  [NUM_LANES-1:0] s3_lanes;
    logic [NUM_LANES-1:0][7:0]  pix;

    assign direction_next = cfg_wr_en ? cfg_wr_data : direction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_FWD;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    // Stage one: pick operands and coefficients for the direction and form all
    // nine weighted products in parallel.
    rycc_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_valid),
        .up_ready  (s1_ready),
        .direction (direction_reg),
        .comp_a    (comp_a),
        .comp_b    (comp_b),
        .comp_c    (comp_c),
        .dn_valid  (s1_valid),
        .dn_ready  (s2_ready),
        .lanes     (s1_lanes)
    );

    // Stage two: add the three products of each lane and split off the sign
    // so the rounding offset can be applied to the magnitude.
    rycc_sum_stage u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_lanes (s1_lanes),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .lanes    (s2_lanes)
    );

    // Stage three: estimate the quotient by 125000 through a fixed reciprocal.
    rycc_recip_stage u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s3_ready),
        .up_lanes (s2_lanes),
        .dn_valid (s3_valid),
        .dn_ready (s4_ready),
        .lanes    (s3_lanes)
    );

    // Stage four: correct the estimate, restore the sign, add the base
    // (zero, the chroma offset or the luma input) and clamp to a byte.
    rycc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s4_ready),
        .up_lanes (s3_lanes),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .pix      (pix)
    );

    assign in_stall = !s1_ready;
    assign out_a    = pix[0];
    assign out_b    = pix[1];
    assign out_c    = pix[2];

    // Backpressure reaches the input when every stage holds a transaction and the output stalls.
    `ASSERT_IMPLIES(a_full_stall,
        s1_valid && s2_valid && s3_valid && out_valid && out_stall,
        in_stall,
        "input accepted while every pipeline stage is full and stalled")

    // The reciprocal estimate must never be off by more than one; checked on the first and third lanes.
    `ASSERT_IMPLIES(a_quo_lane0,
        s3_valid,
        (SCALED_W'(s3_lanes[0].qest) * SCALED_W'(DIVISOR) <= SCALED_W'(s3_lanes[0].mag)) &&
        (SCALED_W'(s3_lanes[0].mag) <
         SCALED_W'(s3_lanes[0].qest) * SCALED_W'(DIVISOR) + SCALED_W'(2 * DIVISOR)),
        "quotient estimate out of range on the first lane")

    `ASSERT_IMPLIES(a_quo_lane2,
        s3_valid,
        (SCALED_W'(s3_lanes[2].qest) * SCALED_W'(DIVISOR) <= SCALED_W'(s3_lanes[2].mag)) &&
        (SCALED_W'(s3_lanes[2].mag) <
         SCALED_W'(s3_lanes[2].qest) * SCALED_W'(DIVISOR) + SCALED_W'(2 * DIVISOR)),
        "quotient estimate out of range on the third lane")

endmodule
